// File: hw/rtl/md5_message_padder_defines.svh
// ---------------------------------------------------------------------------
// MD5 message padder assertion macros
// Shared concurrent assertion templates for the padder checker.
// ---------------------------------------------------------------------------
`ifndef MD5_MESSAGE_PADDER_DEFINES_SVH
`define MD5_MESSAGE_PADDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/mmp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MD5 message padder package
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package mmp_pkg;

  localparam int COUNT_BITS = 61;
  localparam int WORD_BITS  = 64;
  localparam int BYTE_BITS  = 8;

  localparam logic [7:0] SEP_BYTE = 8'h80;

  // Kind of padding word the datapath produces on a padding step.
  typedef enum logic [1:0] {
    PAD_SEP,
    PAD_ZERO,
    PAD_LEN
  } pad_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      take_byte;
    logic      pad_step;
    pad_kind_t pad_kind;
  } mmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic word_six;
  } mmp_status_t;

endpackage

// File: hw/rtl/mmp_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MD5 message padder controller
// Sequences byte intake and the padding burst at the end of a message.
// ---------------------------------------------------------------------------
module mmp_ctrl
  import mmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_has_byte,
  input  logic        in_message_end,
  output logic        in_tready,
  input  mmp_status_t status,
  output mmp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_SEP,
    ST_ZERO,
    ST_LEN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_tready = (state_r == ST_ACCEPT) && status.out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd.take_byte = 1'b0;
    cmd.pad_step  = 1'b0;
    cmd.pad_kind  = PAD_SEP;
    unique case (state_r)
      ST_ACCEPT: begin
        cmd.take_byte = in_fire && in_has_byte;
        if (in_fire && in_message_end) begin
          state_nxt = ST_SEP;
        end
      end
      ST_SEP: begin
        cmd.pad_step = status.out_free;
        cmd.pad_kind = PAD_SEP;
        if (status.out_free) begin
          state_nxt = status.word_six ? ST_LEN : ST_ZERO;
        end
      end
      ST_ZERO: begin
        cmd.pad_step = status.out_free;
        cmd.pad_kind = PAD_ZERO;
        if (status.out_free && status.word_six) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.pad_step = status.out_free;
        cmd.pad_kind = PAD_LEN;
        if (status.out_free) begin
          state_nxt = ST_ACCEPT;
        end
      end
      default: state_nxt = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCEPT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/mmp_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MD5 message padder datapath
// Word assembly, block position, byte counter and output register.
// ---------------------------------------------------------------------------
module mmp_datapath
  import mmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  mmp_cmd_t             cmd,
  input  logic [7:0]           data_byte,
  output mmp_status_t          status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_BITS-1:0] out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast
);

  logic [55:0]            pend_r, pend_nxt;
  logic [5:0]             pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                   out_valid_r;
  logic [WORD_BITS-1:0]   out_word_r;
  logic                   out_blast_r;
  logic                   out_mlast_r;

  logic [2:0]             lane;
  logic [2:0]             widx;
  logic [2:0]             widx_inc;
  logic [5:0]             shamt;
  logic                   emit;
  logic [WORD_BITS-1:0]   word_v;
  logic                   blast_v;
  logic                   mlast_v;

  assign lane     = pos_r[2:0];
  assign widx     = pos_r[5:3];
  assign widx_inc = widx + 3'd1;
  assign shamt    = {lane, 3'b000};

  assign status.out_free = !out_valid_r || out_tready;
  assign status.word_six = (widx == 3'd6);

  always_comb begin
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    word_v   = '0;
    blast_v  = 1'b0;
    mlast_v  = 1'b0;
    if (cmd.take_byte) begin
      pos_nxt = pos_r + 6'd1;
      cnt_nxt = cnt_r + COUNT_BITS'(1);
      if (lane == 3'd7) begin
        emit     = 1'b1;
        word_v   = {data_byte, pend_r};
        blast_v  = (widx == 3'd7);
        pend_nxt = '0;
      end else begin
        pend_nxt = pend_r | (56'(data_byte) << shamt);
      end
    end else if (cmd.pad_step) begin
      emit = 1'b1;
      unique case (cmd.pad_kind)
        PAD_SEP: begin
          word_v   = {8'h00, pend_r} | (WORD_BITS'(SEP_BYTE) << shamt);
          blast_v  = (widx == 3'd7);
          pend_nxt = '0;
          pos_nxt  = {widx_inc, 3'b000};
        end
        PAD_ZERO: begin
          blast_v = (widx == 3'd7);
          pos_nxt = {widx_inc, 3'b000};
        end
        PAD_LEN: begin
          // Length in bits, little-endian, modulo 2^64.
          word_v   = WORD_BITS'({cnt_r, 3'b000});
          blast_v  = 1'b1;
          mlast_v  = 1'b1;
          pend_nxt = '0;
          pos_nxt  = '0;
          cnt_nxt  = '0;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r  <= word_v;
      out_blast_r <= blast_v;
      out_mlast_r <= mlast_v;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_blast_r;
  assign out_tlast  = out_mlast_r;

endmodule

// File: hw/rtl/md5_message_padder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MD5 message padder
// Packs message bytes into 64-bit words of 64-byte MD5 blocks and pads.
// ---------------------------------------------------------------------------
// Usage: message bytes enter on the in_ stream, one transaction per byte,
// with in_tuser high when in_tdata carries a byte and in_tlast high on the
// final transaction of the message (it may carry the last byte or be a
// bare end mark; a bare end mark alone gives the padding of an empty
// message). Words leave on the out_ stream, earliest byte in bits 7..0,
// out_tuser marking the eighth word of a block and out_tlast the final
// word of the padded message.
// Throughput: one byte per cycle while a message streams in. A word is
// shown on out_ the cycle after its eighth byte is taken. The end mark
// starts a padding burst of one word per cycle from the current word to
// the length word: 2 to 9 words, during which in_tready stays low.
// The rate is set by the single output register: each emitted word
// needs a free slot, so a stalled receiver holds off input and padding.
// Reset (rst_n low, synchronous) empties the output register and clears
// the word buffer, block position and byte counter.
// ---------------------------------------------------------------------------
module md5_message_padder
  import mmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tuser,   // [0] has_byte
  input  logic                 in_tlast,   // message_end
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_BITS-1:0] out_tdata,  // [63:0] block_word
  output logic                 out_tuser,  // [0] block_last
  output logic                 out_tlast   // message_last
);

  mmp_cmd_t    cmd;
  mmp_status_t status;

  // The controller owns the handshake on the input side and the padding
  // sequence; the datapath owns all data storage and the output register.
  mmp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_has_byte    (in_tuser),
    .in_message_end (in_tlast),
    .in_tready      (in_tready),
    .status         (status),
    .cmd            (cmd)
  );

  mmp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .data_byte  (in_tdata),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hw/rtl/mmp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MD5 message padder checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "md5_message_padder_defines.svh"

module mmp_checker
  import mmp_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [7:0]           in_tdata,
  input logic                 in_tuser,
  input logic                 in_tlast,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [WORD_BITS-1:0] out_tdata,
  input logic                 out_tuser,
  input logic                 out_tlast
);

  // A stalled word must hold its value.
  `MMP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output changed")

  // The final word of a message also closes a block.
  `MMP_ASSERT_NOW(a_msg_ends_block, clk, rst_n, out_tvalid && out_tlast, out_tuser, "message_last without block_last")

  // The length word counts whole bytes, so its low three bits are zero.
  `MMP_ASSERT_NOW(a_len_bytes, clk, rst_n, out_tvalid && out_tlast, out_tdata[2:0] == 3'b000, "length not a byte multiple")

  // No input is taken while a finished word is stalled.
  `MMP_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, out_tvalid && !out_tready, !in_tready, "input taken during output stall")

endmodule

bind md5_message_padder mmp_checker u_mmp_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MD5 message padder testbench
// Streams byte messages of many lengths into the padder under random
// stalls on both sides. It predicts every padded 64-bit block word and
// checks each word, with its block and message end flags, in order.
// ---------------------------------------------------------------------------
module testbench;
  import mmp_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_WAIT       = 13;       // longest idle stretch of either side
  localparam int RANDOM_BYTES   = 480;      // least number of message transactions in the random part
  localparam int SETTLE_CYCLES  = 24;       // quiet time after the last word arrives
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int LEN_OFFSET     = 56;       // byte of the block where the length starts

  // One input transaction: a message byte, a bare end mark, or neither.
  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       msg_end;
    bit         drain_first;  // hold this one back until every word is out
  } byte_xact_t;

  // One output transaction: a block word with its two end flags.
  typedef struct {
    logic [WORD_BITS-1:0] word;
    logic                 blk_last;
    logic                 msg_last;
  } block_word_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [7:0]           in_tdata   = 8'h00;
  logic                 in_tuser   = 1'b0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tready = 1'b0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [WORD_BITS-1:0] out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;

  // Transactions still to be sent, and words the padder still owes us.
  byte_xact_t  send_q[$];
  block_word_t word_q[$];

  // Shadow of the padder: the partial word, the byte position within the
  // 64-byte block, and the message length so far.
  logic [55:0]           pend_bytes = '0;
  logic [5:0]            blk_pos    = '0;
  logic [COUNT_BITS-1:0] msg_bytes  = '0;

  // Handshakes seen at the last rising edge, read by the drivers at the
  // following falling edge.
  logic in_took  = 1'b0;
  logic out_took = 1'b0;

  int  in_gap     = 0;
  int  out_stall  = 0;
  bit  in_calm    = 1'b0;
  bit  out_calm   = 1'b0;
  int  fail_count = 0;
  int  xacts_in   = 0;
  int  words_out  = 0;
  int  blocks_out = 0;
  int  messages   = 0;

  md5_message_padder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Appends one byte to the shadow block. The eighth byte of a word
  // completes it, and the finished word joins the expected queue.
  function automatic void put_byte(input logic [7:0] b, input logic final_word);
    block_word_t w;
    if (blk_pos[2:0] == 3'd7) begin
      w.word     = {b, pend_bytes};
      w.blk_last = (blk_pos == 6'd63);
      w.msg_last = final_word;
      word_q.push_back(w);
      pend_bytes = '0;
    end else begin
      pend_bytes[blk_pos[2:0] * 8 +: 8] = b;
    end
    blk_pos = blk_pos + 6'd1;
  endfunction

  // Idle cycles before the next transaction on one side. Now and then the
  // side switches between a calm stretch with no idling and a random one.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(24, 0) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(MAX_WAIT, 0);
  endfunction

  task automatic add_xact(input logic [7:0] d, input logic has, input logic fin,
                          input bit drain);
    byte_xact_t x;
    x.data        = d;
    x.has_byte    = has;
    x.msg_end     = fin;
    x.drain_first = drain;
    send_q.push_back(x);
  endtask

  // Input driver. A new transaction goes out at a falling edge once the last
  // was taken, its idle count has run down and any drain it asks for is done.
  always @(negedge clk) begin
    byte_xact_t nxt;
    logic       launch;
    if (rst_n && (!in_tvalid || in_took)) begin
      launch = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (send_q.size() != 0 && !(send_q[0].drain_first && word_q.size() != 0)) begin
        nxt    = send_q.pop_front();
        launch = 1'b1;
        in_gap = draw_wait(in_calm);
      end
      in_tvalid <= launch;
      if (launch) begin
        in_tdata <= nxt.data;
        in_tuser <= nxt.has_byte;
        in_tlast <= nxt.msg_end;
      end
    end
  end

  // Output receiver. After each word it takes, it stalls for a random
  // number of cycles, so stalls land on every point of a padding burst.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) out_stall = draw_wait(out_calm);
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor. Every accepted input transaction is run through the shadow
  // padder; every accepted word is checked against the oldest prediction.
  always @(posedge clk) begin
    logic [63:0] bit_len;
    block_word_t want;
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_tvalid && in_tready;
      out_took <= out_tvalid && out_tready;

      if (in_tvalid && in_tready) begin
        xacts_in++;
        // A byte that comes with the end mark still belongs to the message.
        if (in_tuser) begin
          put_byte(in_tdata, 1'b0);
          msg_bytes = msg_bytes + 1'b1;
        end
        if (in_tlast) begin
          // Separator, zero fill up to the length field (spilling into a
          // new block when the current one is too full), then the length
          // in bits, least significant byte first.
          put_byte(SEP_BYTE, 1'b0);
          while (blk_pos != LEN_OFFSET) put_byte(8'h00, 1'b0);
          bit_len = 64'(msg_bytes) << 3;
          for (int i = 0; i < 8; i++) put_byte(bit_len[i * 8 +: 8], i == 7);
          pend_bytes = '0;
          blk_pos    = '0;
          msg_bytes  = '0;
        end
      end

      if (out_tvalid && out_tready) begin
        words_out++;
        if (out_tuser) blocks_out++;
        if (word_q.size() == 0) begin
          $error("unexpected word %h with no prediction pending", out_tdata);
          fail_count++;
        end else begin
          want = word_q.pop_front();
          if (out_tdata !== want.word) begin
            $error("block_word: expected %h, got %h", want.word, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.blk_last) begin
            $error("block_last: expected %b, got %b", want.blk_last, out_tuser);
            fail_count++;
          end
          if (out_tlast !== want.msg_last) begin
            $error("message_last: expected %b, got %b", want.msg_last, out_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int count;
    int len;
    int sel;
    bit bare;
    bit drain;

    // Directed part. A transaction with neither byte nor end mark must be
    // ignored, and so must the data of a bare end mark.
    add_xact(8'hA5, 1'b0, 1'b0, 1'b0);
    // Empty message: a bare end mark alone, with junk data beside it.
    add_xact(8'hFF, 1'b0, 1'b1, 1'b0);
    // One-byte messages where the byte comes with the end mark.
    add_xact(8'h00, 1'b1, 1'b1, 1'b0);
    add_xact(8'hFF, 1'b1, 1'b1, 1'b0);
    // A short message closed by a bare end mark, then a second empty one
    // right behind it to show the state was cleared.
    add_xact(8'h01, 1'b1, 1'b0, 1'b0);
    add_xact(8'h80, 1'b1, 1'b0, 1'b0);
    add_xact(8'h7F, 1'b1, 1'b0, 1'b0);
    add_xact(8'h00, 1'b0, 1'b1, 1'b0);
    add_xact(8'h00, 1'b0, 1'b1, 1'b0);
    // Exactly one word: the end mark rides on the eighth byte.
    for (int k = 0; k < 8; k++) add_xact(8'(8'h11 * k), 1'b1, k == 7, 1'b0);
    messages = 6;

    // Random part: well-formed messages with random content and random
    // noise transactions mixed in. Lengths favor short messages but also
    // hit the edges of the length field and of whole blocks. The first
    // random message, and some later ones, wait for the padder to drain.
    count = 0;
    while (count < RANDOM_BYTES) begin
      sel = $urandom_range(9, 0);
      case (sel)
        0: len = 0;
        1, 2, 3, 4: len = $urandom_range(20, 1);
        5: begin
          case ($urandom_range(5, 0))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            default: len = 65;
          endcase
        end
        6: len = $urandom_range(130, 21);
        default: len = $urandom_range(64, 1);
      endcase
      bare  = (len == 0) || ($urandom_range(1, 0) == 1);
      drain = (messages == 6) || ($urandom_range(19, 0) == 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(15, 0) == 0) add_xact(8'($urandom), 1'b0, 1'b0, 1'b0);
        add_xact(8'($urandom), 1'b1, !bare && k == len - 1, drain && k == 0);
        count++;
      end
      if (bare) begin
        add_xact(8'($urandom), 1'b0, 1'b1, drain && len == 0);
        count++;
      end
      messages++;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    while (send_q.size() != 0 || in_tvalid || word_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d messages in %0d input transactions.", messages, xacts_in);
    $display("Checked %0d block words making up %0d blocks.", words_out, blocks_out);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timed out with %0d words still expected.", word_q.size());
    $display("testbench: errors");
    $finish;
  end

endmodule
